// ----- src/sam_pkg.sv -----
// Shared types, constants and helper functions for the stereo audio mixer.
// No dependencies; every other file of the mixer imports this package.
package sam_pkg;

  localparam int SAMPLE_W = 8;
  localparam int MIX_W    = 10;
  localparam int GAIN_W   = 9;
  localparam int PROD_W   = 20;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TONE_EN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TONE_EN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_LEVEL     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LEVEL    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_SHIFT     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DMA_A_FULL     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DMA_B_FULL     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DMA_ROUTES     = 4'd7;

  localparam logic signed [11:0] MIX_MAX = 12'sd511;
  localparam logic signed [11:0] MIX_MIN = -12'sd512;

  // dma_routes bits
  localparam int ROUTE_A_LEFT  = 0;
  localparam int ROUTE_A_RIGHT = 1;
  localparam int ROUTE_B_LEFT  = 2;
  localparam int ROUTE_B_RIGHT = 3;

  typedef struct packed {
    logic [3:0] left_tone_enables;
    logic [3:0] right_tone_enables;
    logic [2:0] left_master_level;
    logic [2:0] right_master_level;
    logic [1:0] tone_shift_select;
    logic       dma_a_full_volume;
    logic       dma_b_full_volume;
    logic [3:0] dma_routes;
  } cfg_t;

  // after summing
  typedef struct packed {
    logic signed [MIX_W-1:0] tone_l;
    logic signed [MIX_W-1:0] tone_r;
    logic signed [MIX_W-1:0] dma_l;
    logic signed [MIX_W-1:0] dma_r;
    logic [GAIN_W-1:0]       gain_l;
    logic [GAIN_W-1:0]       gain_r;
    logic [1:0]              shift_sel;
  } sum_t;

  // after gain multiply
  typedef struct packed {
    logic signed [PROD_W-1:0] prod_l;
    logic signed [PROD_W-1:0] prod_r;
    logic signed [MIX_W-1:0]  dma_l;
    logic signed [MIX_W-1:0]  dma_r;
    logic [1:0]               shift_sel;
  } prod_t;

  function automatic logic [GAIN_W-1:0] gain_lookup(input logic [2:0] level);
    logic [GAIN_W-1:0] g;
    case (level)
      3'd0:    g = 9'h000;
      3'd1:    g = 9'h024;
      3'd2:    g = 9'h049;
      3'd3:    g = 9'h06d;
      3'd4:    g = 9'h092;
      3'd5:    g = 9'h0b6;
      3'd6:    g = 9'h0db;
      default: g = 9'h100;
    endcase
    return g;
  endfunction

  function automatic logic signed [MIX_W-1:0] clip10(input logic signed [11:0] v);
    logic signed [MIX_W-1:0] r;
    if (v > MIX_MAX) begin
      r = MIX_MAX[MIX_W-1:0];
    end else if (v < MIX_MIN) begin
      r = MIX_MIN[MIX_W-1:0];
    end else begin
      r = v[MIX_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/sam_frame_if.sv -----
// Input channel of the mixer: one stereo frame of six signed samples.
// Depends on sam_pkg.
interface sam_frame_if;
  import sam_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] tone1_sample;
  logic signed [SAMPLE_W-1:0] tone2_sample;
  logic signed [SAMPLE_W-1:0] tone3_sample;
  logic signed [SAMPLE_W-1:0] tone4_sample;
  logic signed [SAMPLE_W-1:0] fifo_a_sample;
  logic signed [SAMPLE_W-1:0] fifo_b_sample;

  modport source (output valid, tone1_sample, tone2_sample, tone3_sample, tone4_sample,
                  fifo_a_sample, fifo_b_sample, input ready);
  modport sink (input valid, tone1_sample, tone2_sample, tone3_sample, tone4_sample,
                fifo_a_sample, fifo_b_sample, output ready);
endinterface

// ----- src/sam_mix_if.sv -----
// Output channel of the mixer: one clipped stereo sample pair.
// Depends on sam_pkg.
interface sam_mix_if;
  import sam_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [MIX_W-1:0] left_out;
  logic signed [MIX_W-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

// ----- src/sam_cfg_if.sv -----
// Register write channel of the mixer: index and write data.
// Depends on sam_pkg.
interface sam_cfg_if;
  import sam_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/stereo_audio_mixer_clip.sv -----
// Stereo audio mixer with clipping: top level.
// Depends on sam_pkg, the three channel interfaces, sam_regs, sam_sum,
// sam_gain and sam_mix.
//
// Takes one frame per clock cycle while the output is not stalled, and returns
// its mixed stereo pair through three register stages: clipped
// sums and gain lookup, gain multiply, then shift, DMA add and final clip.
// The last stage is the output register, so a stalled output holds up to
// three frames and backpressure reaches the input only when all three are
// full. Register writes are taken in any cycle; change registers only while
// no frame is in flight.
module stereo_audio_mixer_clip (
  input logic         clk,
  input logic         rst,
  sam_frame_if.sink   in_frame,
  sam_mix_if.source   out_mix,
  sam_cfg_if.sink     cfg
);
  import sam_pkg::*;

  cfg_t  regs;
  logic  sum_valid;
  logic  sum_ready;
  sum_t  sum_data;
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod_data;

  assign cfg.ready = 1'b1;

  sam_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid && cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (regs)
  );

  sam_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .in_valid  (in_frame.valid),
    .in_ready  (in_frame.ready),
    .tone1     (in_frame.tone1_sample),
    .tone2     (in_frame.tone2_sample),
    .tone3     (in_frame.tone3_sample),
    .tone4     (in_frame.tone4_sample),
    .fifo_a    (in_frame.fifo_a_sample),
    .fifo_b    (in_frame.fifo_b_sample),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_data  (sum_data)
  );

  sam_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_data   (sum_data),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  sam_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (out_mix.valid),
    .out_ready (out_mix.ready),
    .left_out  (out_mix.left_out),
    .right_out (out_mix.right_out)
  );

  // input stalls only when every stage holds a frame
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_frame.ready |-> (sum_valid && prod_valid && out_mix.valid))
    else $error("input stalled with an empty stage");

  // a frame entering an empty pipeline reaches out_mix.valid after passing each stage register
  a_latency_empty: assert property (@(posedge clk) disable iff (rst)
    (in_frame.valid && in_frame.ready && !sum_valid && !prod_valid && !out_mix.valid)
    |=> ##2 out_mix.valid)
    else $error("frame not delivered at expected latency");

  // a stage that holds a frame while stalled keeps it
  a_mid_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (prod_valid && !prod_ready) |=> (prod_valid && $stable(prod_data)))
    else $error("multiply stage lost or changed a stalled frame");
endmodule

// ----- src/sam_regs.sv -----
// Configuration register file of the mixer.
// Depends on sam_pkg; writes arrive from the top level's register channel.
module sam_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [sam_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [sam_pkg::CFG_DATA_W-1:0] wr_data,
  output sam_pkg::cfg_t                  cfg
);
  import sam_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_LEFT_TONE_EN:  cfg.left_tone_enables  <= wr_data[3:0];
        REG_RIGHT_TONE_EN: cfg.right_tone_enables <= wr_data[3:0];
        REG_LEFT_LEVEL:    cfg.left_master_level  <= wr_data[2:0];
        REG_RIGHT_LEVEL:   cfg.right_master_level <= wr_data[2:0];
        REG_TONE_SHIFT:    cfg.tone_shift_select  <= wr_data[1:0];
        REG_DMA_A_FULL:    cfg.dma_a_full_volume  <= wr_data[0];
        REG_DMA_B_FULL:    cfg.dma_b_full_volume  <= wr_data[0];
        REG_DMA_ROUTES:    cfg.dma_routes         <= wr_data[3:0];
        default: ;
      endcase
    end
  end
endmodule

// ----- src/sam_sum.sv -----
// Stage 1: clipped tone and DMA sums per side, gain table lookup.
// Depends on sam_pkg; fed by the input channel and the register file.
module sam_sum (
  input  logic                                clk,
  input  logic                                rst,
  input  sam_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sam_pkg::SAMPLE_W-1:0] tone1,
  input  logic signed [sam_pkg::SAMPLE_W-1:0] tone2,
  input  logic signed [sam_pkg::SAMPLE_W-1:0] tone3,
  input  logic signed [sam_pkg::SAMPLE_W-1:0] tone4,
  input  logic signed [sam_pkg::SAMPLE_W-1:0] fifo_a,
  input  logic signed [sam_pkg::SAMPLE_W-1:0] fifo_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sam_pkg::sum_t                       out_data
);
  import sam_pkg::*;

  function automatic logic signed [MIX_W-1:0] tone_sum(
    input logic [3:0] en,
    input logic signed [SAMPLE_W-1:0] t1,
    input logic signed [SAMPLE_W-1:0] t2,
    input logic signed [SAMPLE_W-1:0] t3,
    input logic signed [SAMPLE_W-1:0] t4
  );
    logic signed [MIX_W-1:0] acc;
    acc = '0;
    if (en[0]) acc = clip10(12'(acc) + 12'(t1));
    if (en[1]) acc = clip10(12'(acc) + 12'(t2));
    if (en[2]) acc = clip10(12'(acc) + 12'(t3));
    if (en[3]) acc = clip10(12'(acc) + 12'(t4));
    return acc;
  endfunction

  function automatic logic signed [MIX_W-1:0] dma_sum(
    input logic use_a,
    input logic use_b,
    input logic signed [MIX_W-1:0] a,
    input logic signed [MIX_W-1:0] b
  );
    logic signed [MIX_W-1:0] acc;
    acc = '0;
    if (use_a) acc = clip10(12'(acc) + 12'(a));
    if (use_b) acc = clip10(12'(acc) + 12'(b));
    return acc;
  endfunction

  logic signed [MIX_W-1:0] dma_a;
  logic signed [MIX_W-1:0] dma_b;
  sum_t                    sum_next;

  assign dma_a = cfg.dma_a_full_volume ? {fifo_a[SAMPLE_W-1], fifo_a, 1'b0}
                                       : MIX_W'(fifo_a);
  assign dma_b = cfg.dma_b_full_volume ? {fifo_b[SAMPLE_W-1], fifo_b, 1'b0}
                                       : MIX_W'(fifo_b);

  always_comb begin
    sum_next.tone_l    = tone_sum(cfg.left_tone_enables, tone1, tone2, tone3, tone4);
    sum_next.tone_r    = tone_sum(cfg.right_tone_enables, tone1, tone2, tone3, tone4);
    sum_next.dma_l     = dma_sum(cfg.dma_routes[ROUTE_A_LEFT], cfg.dma_routes[ROUTE_B_LEFT],
                                 dma_a, dma_b);
    sum_next.dma_r     = dma_sum(cfg.dma_routes[ROUTE_A_RIGHT], cfg.dma_routes[ROUTE_B_RIGHT],
                                 dma_a, dma_b);
    sum_next.gain_l    = gain_lookup(cfg.left_master_level);
    sum_next.gain_r    = gain_lookup(cfg.right_master_level);
    sum_next.shift_sel = cfg.tone_shift_select;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= sum_next;
    end
  end
endmodule

// ----- src/sam_gain.sv -----
// Stage 2: master gain multiply of the tone sums.
// Depends on sam_pkg; sits between sam_sum and sam_mix.
module sam_gain (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sam_pkg::sum_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sam_pkg::prod_t out_data
);
  import sam_pkg::*;

  logic signed [MIX_W-1:0] gain_l;
  logic signed [MIX_W-1:0] gain_r;
  prod_t                   prod_next;

  assign gain_l = {1'b0, in_data.gain_l};
  assign gain_r = {1'b0, in_data.gain_r};

  always_comb begin
    prod_next.prod_l    = in_data.tone_l * gain_l;
    prod_next.prod_r    = in_data.tone_r * gain_r;
    prod_next.dma_l     = in_data.dma_l;
    prod_next.dma_r     = in_data.dma_r;
    prod_next.shift_sel = in_data.shift_sel;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= prod_next;
    end
  end
endmodule

// ----- src/sam_mix.sv -----
// Stage 3: tone shift, DMA add and final clip into the output register.
// Depends on sam_pkg; drives the output channel through the top level.
module sam_mix (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sam_pkg::prod_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [sam_pkg::MIX_W-1:0] left_out,
  output logic signed [sam_pkg::MIX_W-1:0] right_out
);
  import sam_pkg::*;

  function automatic logic signed [11:0] tone_shift(
    input logic signed [PROD_W-1:0] p,
    input logic [1:0]               sel
  );
    logic signed [PROD_W-1:0] s;
    case (sel)
      2'd0:    s = p >>> 10;
      2'd1:    s = p >>> 9;
      2'd2:    s = p >>> 8;
      default: s = p >>> 7;
    endcase
    return s[11:0];
  endfunction

  logic signed [11:0]      tone_l;
  logic signed [11:0]      tone_r;
  logic signed [MIX_W-1:0] left_next;
  logic signed [MIX_W-1:0] right_next;

  assign tone_l     = tone_shift(in_data.prod_l, in_data.shift_sel);
  assign tone_r     = tone_shift(in_data.prod_r, in_data.shift_sel);
  assign left_next  = clip10(tone_l + 12'(in_data.dma_l));
  assign right_next = clip10(tone_r + 12'(in_data.dma_r));

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      left_out  <= left_next;
      right_out <= right_next;
    end
  end
endmodule
